// ----- src/mdlr_pkg.sv -----
package mdlr_pkg;

   // default sizes of the frame memory and the sample word
   localparam int DEF_FRAME_DEPTH = 16384;
   localparam int DEF_SAMPLE_BITS = 24;

   // action codes carried in tuser of the request channel
   localparam int ACT_W = 2;
   localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FETCH = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   // register file
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_CHANNELS = 1'b0;
   localparam logic REG_STEP     = 1'b1;

   localparam int CH_W   = 4;
   localparam int STEP_W = 21;
   localparam logic [CH_W-1:0]   CH_RESET   = 4'd1;
   localparam logic [CH_W-1:0]   CH_MAX     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

   // read position is unsigned Q15.16, run counter saturates at RUN_CAP
   localparam int POS_W  = 31;
   localparam int FRAC_W = 16;
   localparam int CNT_W  = 15;
   localparam logic [CNT_W-1:0] RUN_CAP = 15'd32767;

   // run-end compare width: (count + 2) * step and frames << 16
   localparam int BOUND_W = 38;

   // floor(2^35 / n) for n = 1..8, scaled down to the sum width in use
   localparam int RECIP_K = 35;
   localparam logic [RECIP_K:0] RECIP_TABLE [8] = '{
      36'd34359738368, 36'd17179869184, 36'd11453246122, 36'd8589934592,
      36'd6871947673,  36'd5726623061,  36'd4908534052,  36'd4294967296
   };

   // control of the frame averager
   typedef struct packed {
      logic       start;
      logic [2:0] n_m1;
   } avg_ctl_type;

endpackage

// ----- src/mdlr_frame_mem.sv -----
module mdlr_frame_mem #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 24,
   parameter int AW    = 14
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr0,
   input  logic [AW-1:0]    rd_addr1,
   output logic [WIDTH-1:0] rd_data0,
   output logic [WIDTH-1:0] rd_data1
);

   logic [WIDTH-1:0] mono_store_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mono_store_ff[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= mono_store_ff[rd_addr0];
         rd1_ff <= mono_store_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ----- src/mdlr_avg.sv -----
module mdlr_avg #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mdlr_pkg::avg_ctl_type       ctl,
   input  logic signed [SAMPLE_BITS+2:0] sum,
   output logic                        done,
   output logic [SAMPLE_BITS+2:0]      mean   // full width, a frame may hold extra samples
);
   import mdlr_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + 3;
   localparam int MAG_W  = SAMPLE_BITS + 3;
   localparam int RCP_W  = MAG_W + 1;
   localparam int PROD_W = MAG_W + RCP_W;
   localparam int QW     = MAG_W + 4;

   logic go0_ff, go1_ff, go2_ff;
   logic signed [SUM_W-1:0] sum0_ff;
   logic [2:0] n0_ff, n1_ff, n2_ff;
   logic neg1_ff, neg2_ff;
   logic [MAG_W-1:0] mag1_ff, mag2_ff;
   logic [PROD_W-1:0] prod2_ff;

   logic [CH_W-1:0] n0, n2;
   logic [SUM_W-1:0] abs_val;
   logic [MAG_W-1:0] mag_in;
   logic [RCP_W-1:0] recip;
   logic [PROD_W-1:0] prod_in;
   logic [MAG_W-1:0] q_est, q_fix, q_neg;
   logic [QW-1:0] qn, rem;

   // magnitude plus half the divisor, so the floor rounds to nearest
   assign n0      = {1'b0, n0_ff} + 4'd1;
   assign abs_val = sum0_ff[SUM_W-1] ? (~sum0_ff + 1'b1) : sum0_ff;
   assign mag_in  = MAG_W'(abs_val) + MAG_W'(n0 >> 1);

   // reciprocal multiply, estimate is low by at most one
   assign recip   = RCP_W'(RECIP_TABLE[n1_ff] >> (RECIP_K - MAG_W));
   assign prod_in = PROD_W'(mag1_ff) * PROD_W'(recip);

   // correction step and sign
   assign n2    = {1'b0, n2_ff} + 4'd1;
   assign q_est = prod2_ff[MAG_W +: MAG_W];
   assign qn    = QW'(q_est) * QW'(n2);
   assign rem   = QW'(mag2_ff) - qn;
   assign q_fix = (rem >= QW'(n2)) ? q_est + 1'b1 : q_est;
   assign q_neg = ~q_fix + 1'b1;
   assign mean  = neg2_ff ? q_neg : q_fix;
   assign done  = go2_ff;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         go0_ff <= 1'b0;
         go1_ff <= 1'b0;
         go2_ff <= 1'b0;
      end else begin
         go0_ff <= ctl.start;
         go1_ff <= go0_ff;
         go2_ff <= go1_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         sum0_ff <= sum;
         n0_ff   <= ctl.n_m1;
      end
      if (go0_ff) begin
         mag1_ff <= mag_in;
         neg1_ff <= sum0_ff[SUM_W-1];
         n1_ff   <= n0_ff;
      end
      if (go1_ff) begin
         prod2_ff <= prod_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         n2_ff    <= n1_ff;
      end
   end

endmodule

// ----- src/mdlr_interp.sv -----
module mdlr_interp #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [SAMPLE_BITS-1:0] a,
   input  logic [SAMPLE_BITS-1:0] b,
   input  logic [15:0]            frac,
   output logic [SAMPLE_BITS-1:0] value
);

   localparam int DW   = SAMPLE_BITS + 1;
   localparam int PW   = SAMPLE_BITS + 18;
   localparam int ACCW = SAMPLE_BITS + 19;

   logic signed [DW-1:0]   diff;
   logic signed [PW-1:0]   prod_in;
   logic signed [PW-1:0]   prod_ff;
   logic [SAMPLE_BITS-1:0] a_ff;
   logic signed [ACCW-1:0] acc;

   // weighted difference, registered
   assign diff    = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
   assign prod_in = PW'(diff) * PW'($signed({1'b0, frac}));

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
   end

   // a * 65536 + weighted difference + half, floor by 65536
   assign acc = ($signed({{19{a_ff[SAMPLE_BITS-1]}}, a_ff}) <<< 16)
              + ACCW'(prod_ff) + ACCW'(32768);
   assign value = acc[16 +: SAMPLE_BITS];

endmodule

// ----- src/mono_downmix_linear_resampler_unit.sv -----
// channel   direction   handshake              payload
// req       in          req_tvalid/req_tready  tdata: sample_in, tuser: action
// rsp       out         rsp_tvalid/rsp_tready  tdata: sample_out, tlast, tuser: past_end
// csr       in/out      psel/penable, pready   channel_count at 0x0, step_ratio at 0x4
//
// load that does not close a frame and clear end in the idle state; a load that
// closes a frame passes the three-stage averager and then the memory write.
// fetch passes through frame memory read, interpolation multiply, output load.
// a fetch result waits in the output register while rsp_tready is low; the
// next beat is taken meanwhile, and a following fetch holds until it drains.
// reset is synchronous; the frame memory is not cleared and needs no sweep.
module mono_downmix_linear_resampler_unit #(
   parameter int FRAME_DEPTH = mdlr_pkg::DEF_FRAME_DEPTH,
   parameter int SAMPLE_BITS = mdlr_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // sample_in
   input  logic [mdlr_pkg::ACT_W-1:0]             req_tuser,  // action
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,  // sample_out
   output logic                                   rsp_tlast,  // last_out
   output logic [0:0]                             rsp_tuser,  // past_end
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mdlr_pkg::CSR_AW-1:0]            csr_paddr,
   input  logic [mdlr_pkg::CSR_DW-1:0]            csr_pwdata,
   output logic [mdlr_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                   csr_pready
);
   import mdlr_pkg::*;

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SUM_W  = SAMPLE_BITS + 3;
   localparam int FT_W   = $clog2(FRAME_DEPTH + 1);
   localparam int AW     = $clog2(FRAME_DEPTH);
   localparam int IW     = (FT_W > CNT_W) ? FT_W : CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_AVG  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [CH_W-1:0] cc_ff;
   logic [STEP_W-1:0] step_ff;
   logic [FT_W-1:0] ft_ff, ft_in;
   logic [2:0] ch_pos_ff, ch_pos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [CNT_W-1:0] done_ff, done_in;
   logic [BOUND_W-1:0] bound_ff, bound_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_pe_ff, rsp_pe_in;

   logic req_accept, csr_write;
   logic [CH_W-1:0] n_eff, ch_inc;
   logic [STEP_W-1:0] step_eff;
   logic signed [SUM_W-1:0] sum_next;
   logic frame_close;
   logic [IW-1:0] ft_ext, int_ext, idx0;
   logic [IW:0] idx0_inc;
   logic [IW-1:0] idx1;
   logic [CNT_W:0] cnt_inc;
   logic [BOUND_W-1:0] x_val;
   logic past_end, run_last;

   avg_ctl_type avg_ctl;
   logic avg_done;
   logic [SUM_W-1:0] avg_mean;
   logic mem_wr_en, mem_rd_en, interp_en;
   logic [SUM_W-1:0] rd_a, rd_b, interp_value;

   // config port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         REG_CHANNELS: csr_prdata = CSR_DW'(cc_ff);
         REG_STEP:     csr_prdata = CSR_DW'(step_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff   <= CH_RESET;
         step_ff <= STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_CHANNELS: cc_ff   <= csr_pwdata[CH_W-1:0];
            REG_STEP:     step_ff <= csr_pwdata[STEP_W-1:0];
            default:      ;
         endcase
      end
   end

   // effective settings
   assign n_eff    = (cc_ff == '0) ? 4'd1 : ((cc_ff > CH_MAX) ? CH_MAX : cc_ff);
   assign step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;

   // request beat and accumulation
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign sum_next    = sum_ff + SUM_W'($signed(req_tdata[SAMPLE_BITS-1:0]));
   assign ch_inc      = {1'b0, ch_pos_ff} + 4'd1;
   assign frame_close = (ch_inc >= n_eff);

   // frame addresses, clamped to the last frame
   assign ft_ext   = IW'(ft_ff);
   assign int_ext  = IW'(position_ff[POS_W-1:FRAC_W]);
   assign idx0     = (int_ext >= ft_ext) ? ft_ext - 1'b1 : int_ext;
   assign idx0_inc = {1'b0, idx0} + 1'b1;
   assign idx1     = (idx0_inc < {1'b0, ft_ext}) ? idx0_inc[IW-1:0] : idx0;

   // run end: count >= floor(frames * 65536 / step) against (count + 1) * step
   assign cnt_inc = {1'b0, done_ff} + 1'b1;
   assign x_val   = BOUND_W'({ft_ff, 16'b0});
   assign past_end = (ft_ff == '0) || (done_ff == RUN_CAP)
                   || ((done_ff != '0) && (x_val < bound_ff));
   assign run_last = (done_ff == RUN_CAP - 1'b1)
                   || (x_val < bound_ff + BOUND_W'(step_eff));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ft_in         = ft_ff;
      ch_pos_in     = ch_pos_ff;
      sum_in        = sum_ff;
      position_in   = position_ff;
      done_in       = done_ff;
      bound_in      = bound_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_pe_in     = rsp_pe_ff;
      avg_ctl.start = 1'b0;
      avg_ctl.n_m1  = 3'(n_eff - 1'b1);
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      interp_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_tuser)
                  ACT_LOAD: begin
                     if (frame_close) begin
                        avg_ctl.start = 1'b1;
                        sum_in        = '0;
                        ch_pos_in     = '0;
                        state_in      = ST_AVG;
                     end else begin
                        sum_in    = sum_next;
                        ch_pos_in = ch_inc[2:0];
                     end
                  end
                  ACT_FETCH: begin
                     mem_rd_en = 1'b1;
                     bound_in  = BOUND_W'(cnt_inc) * BOUND_W'(step_eff);
                     state_in  = ST_READ;
                  end
                  ACT_CLEAR: begin
                     ft_in       = '0;
                     ch_pos_in   = '0;
                     sum_in      = '0;
                     position_in = '0;
                     done_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_AVG: begin
            if (avg_done) begin
               if (ft_ff < FT_W'(FRAME_DEPTH)) begin
                  mem_wr_en = 1'b1;
                  ft_in     = ft_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            interp_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (past_end) begin
                  rsp_sample_in = '0;
                  rsp_last_in   = 1'b0;
                  rsp_pe_in     = 1'b1;
               end else begin
                  rsp_sample_in = interp_value[SAMPLE_BITS-1:0];
                  rsp_last_in   = run_last;
                  rsp_pe_in     = 1'b0;
                  done_in       = cnt_inc[CNT_W-1:0];
                  position_in   = position_ff + POS_W'(step_eff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ft_ff        <= '0;
         ch_pos_ff    <= '0;
         sum_ff       <= '0;
         position_ff  <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ft_ff        <= ft_in;
         ch_pos_ff    <= ch_pos_in;
         sum_ff       <= sum_in;
         position_ff  <= position_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      bound_ff      <= bound_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_pe_ff     <= rsp_pe_in;
   end

   // output beat
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = DATA_W'(rsp_sample_ff);
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_pe_ff;

   mdlr_avg #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_avg (
      .clock(clock),
      .reset(reset),
      .ctl  (avg_ctl),
      .sum  (sum_next),
      .done (avg_done),
      .mean (avg_mean)
   );

   // frames keep the full average width: after a channel count drop a frame
   // can gather more samples than it divides by
   mdlr_frame_mem #(
      .DEPTH(FRAME_DEPTH),
      .WIDTH(SUM_W),
      .AW   (AW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (AW'(ft_ff)),
      .wr_data (avg_mean),
      .rd_en   (mem_rd_en),
      .rd_addr0(AW'(idx0)),
      .rd_addr1(AW'(idx1)),
      .rd_data0(rd_a),
      .rd_data1(rd_b)
   );

   mdlr_interp #(
      .SAMPLE_BITS(SUM_W)
   ) u_interp (
      .clock(clock),
      .en   (interp_en),
      .a    (rd_a),
      .b    (rd_b),
      .frac (position_ff[FRAC_W-1:0]),
      .value(interp_value)
   );

endmodule

// ----- src/mdlr_checker.sv -----
module mdlr_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic [0:0]                       rsp_tuser
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // no result can appear the cycle after a request beat
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result beat appeared one cycle after a request beat");

   // a past-end beat carries no sample and no last mark
   a_past_end_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("past-end beat with data or last");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

endmodule

bind mono_downmix_linear_resampler_unit mdlr_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_mdlr_checker (.*);
